FILE: rtl/rmsd_pkg.sv
package rmsd_pkg;

    // Marker size in bytes (4 to 8) and derived widths
    localparam int MARKER_BYTES = 4;
    localparam int MARKER_W     = 8 * MARKER_BYTES;
    localparam int POS_W        = $clog2(MARKER_BYTES);
    localparam int LEN_W        = 31;

    // Queue between the front and back parts
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    typedef enum logic [2:0] {
        ST_RUN      = 3'd0,
        ST_END      = 3'd1,
        ST_NEG      = 3'd2,
        ST_SHORT    = 3'd3,
        ST_MISMATCH = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_TRAILER = 3'b100
    } phase_t;

    // What the back part does with one queued item
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_MARKER = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        status_t               status;
        logic [MARKER_W-1:0]   data;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_flags_t;

endpackage

FILE: rtl/rmsd_in_if.sv
interface rmsd_in_if
    import rmsd_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

FILE: rtl/rmsd_out_if.sv
interface rmsd_out_if
    import rmsd_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output out_byte, output has_byte, output status,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input status,
                    input last, output ready);
endinterface

FILE: rtl/rmsd_front.sv
module rmsd_front
    import rmsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rmsd_in_if.sink      in_stream,
    output logic         push,
    output work_t        push_item,
    input  queue_flags_t flags
);

    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [MARKER_W-1:0] gather_reg, gather_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    left_reg, left_next;
    status_t             stop_reg, stop_next;

    logic [MARKER_W-1:0] gather_shift;
    logic                oversize;

    // Accept whenever the queue has room
    assign in_stream.ready = !flags.full;
    assign push            = in_stream.valid && in_stream.ready;

    assign gather_shift = {gather_reg[MARKER_W-9:0], in_stream.in_byte};
    assign oversize     = |gather_shift[MARKER_W-1:LEN_W];

    // Classify the item and work out the next framing state
    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        gather_next    = gather_reg;
        len_next       = len_reg;
        left_next      = left_reg;
        stop_next      = stop_reg;
        push_item.kind = KIND_NONE;
        push_item.data = '0;

        if (stop_reg != ST_RUN)
        begin
            // stopped: status only
        end
        else if (in_stream.end_of_input)
        begin
            case (phase_reg)
                PH_HEADER:  stop_next = ST_END;
                PH_PAYLOAD: stop_next = ST_SHORT;
                default:    stop_next = ST_MISMATCH;
            endcase
        end
        else if (phase_reg == PH_PAYLOAD)
        begin
            push_item.kind = KIND_BYTE;
            push_item.data = MARKER_W'(in_stream.in_byte);
            left_next      = left_reg - LEN_W'(1);
            if (left_reg == LEN_W'(1))
            begin
                phase_next  = PH_TRAILER;
                pos_next    = '0;
                gather_next = '0;
            end
        end
        else
        begin
            gather_next = gather_shift;
            if (pos_reg != POS_W'(MARKER_BYTES - 1))
            begin
                pos_next = pos_reg + POS_W'(1);
            end
            else
            begin
                pos_next = '0;
                if (oversize)
                begin
                    stop_next = (phase_reg == PH_HEADER) ? ST_NEG : ST_MISMATCH;
                end
                else
                begin
                    push_item.kind = KIND_MARKER;
                    push_item.data = gather_shift;
                    gather_next    = '0;
                    if (phase_reg == PH_HEADER)
                    begin
                        len_next   = gather_shift[LEN_W-1:0];
                        left_next  = gather_shift[LEN_W-1:0];
                        phase_next = (gather_shift[LEN_W-1:0] == '0) ? PH_TRAILER
                                                                     : PH_PAYLOAD;
                    end
                    else
                    begin
                        if (gather_shift[LEN_W-1:0] != len_reg)
                        begin
                            stop_next = ST_MISMATCH;
                        end
                        phase_next = PH_HEADER;
                    end
                end
            end
        end

        push_item.status = stop_next;
    end

    // Framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            gather_reg <= '0;
            len_reg    <= '0;
            left_reg   <= '0;
            stop_reg   <= ST_RUN;
        end
        else if (push)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            gather_reg <= gather_next;
            len_reg    <= len_next;
            left_reg   <= left_next;
            stop_reg   <= stop_next;
        end
    end

    // Once stopped, nothing but status goes out
    assert property (@(posedge clk) disable iff (!rst_n)
        push && (stop_reg != ST_RUN) |-> push_item.kind == KIND_NONE)
        else $error("front: byte queued after stop");

    // Payload phase always has bytes left to pass
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> left_reg != '0)
        else $error("front: payload phase with zero count");

endmodule

FILE: rtl/rmsd_queue.sv
module rmsd_queue
    import rmsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  work_t        push_item,
    input  logic         pop,
    output work_t        head,
    output queue_flags_t flags
);

    work_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign head        = entry_reg[rd_ptr_reg];
    assign flags.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign flags.empty = (count_reg == '0);

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !flags.full)
        else $error("queue: write while full");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !flags.empty)
        else $error("queue: read while empty");

endmodule

FILE: rtl/rmsd_back.sv
module rmsd_back
    import rmsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  work_t        head,
    input  queue_flags_t flags,
    output logic         pop,
    rmsd_out_if.source   out_stream
);

    logic [POS_W-1:0] piece_reg, piece_next;
    logic             valid_reg;
    logic [7:0]       byte_reg, byte_next;
    logic             has_reg, has_next;
    status_t          status_reg;
    logic             last_reg, last_next;

    logic             load;
    logic             piece_last;

    // Load the output register when the queue has an item and the register is empty or being taken
    assign load       = !flags.empty && (!valid_reg || out_stream.ready);
    assign piece_last = (head.kind != KIND_MARKER) ||
                        (piece_reg == POS_W'(MARKER_BYTES - 1));
    assign pop        = load && piece_last;

    // Pick the byte for this result; markers go out low byte first
    always_comb
    begin
        piece_next = piece_reg;
        if (load)
        begin
            piece_next = piece_last ? '0 : piece_reg + POS_W'(1);
        end

        case (head.kind)
            KIND_MARKER:
            begin
                byte_next = head.data[{piece_reg, 3'b000} +: 8];
                has_next  = 1'b1;
            end
            KIND_BYTE:
            begin
                byte_next = head.data[7:0];
                has_next  = 1'b1;
            end
            default:
            begin
                byte_next = '0;
                has_next  = 1'b0;
            end
        endcase
        last_next = piece_last;
    end

    // Output register and piece counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            piece_reg <= '0;
        end
        else
        begin
            piece_reg <= piece_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_stream.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= byte_next;
            has_reg    <= has_next;
            status_reg <= head.status;
            last_reg   <= last_next;
        end
    end

    assign out_stream.valid    = valid_reg;
    assign out_stream.out_byte = byte_reg;
    assign out_stream.has_byte = has_reg;
    assign out_stream.status   = status_reg;
    assign out_stream.last     = last_reg;

    // Part way through a marker the head must still be that marker
    assert property (@(posedge clk) disable iff (!rst_n)
        piece_reg != '0 |-> !flags.empty && head.kind == KIND_MARKER)
        else $error("back: marker expansion lost its item");

endmodule

FILE: rtl/record_marker_swap_deframer_core.sv
// Record marker swap deframer: one byte item accepted per cycle while the queue has room.
// An accepted item is written into the queue, then loaded into the output register when that is free.
// Throughput: one result per cycle from the output register while the sink is ready; a marker item expands
// to MARKER_BYTES results, so output bandwidth sets the long-run item rate.
// Reset: asynchronous, active low; framing restarts in the header phase, queue empties.
module record_marker_swap_deframer_core
    import rmsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rmsd_in_if.sink     in_stream,
    rmsd_out_if.source  out_stream
);

    logic         push;
    logic         pop;
    work_t        push_item;
    work_t        head;
    queue_flags_t flags;

    rmsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_stream (in_stream),
        .push      (push),
        .push_item (push_item),
        .flags     (flags)
    );

    rmsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .flags     (flags)
    );

    rmsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .flags      (flags),
        .pop        (pop),
        .out_stream (out_stream)
    );

endmodule
